FILE: src/nnd_pkg.sv
// ----------------------------------------------------------------------------
// nnd_pkg
// Shared constants and codes for the nearest node distance block.
// ----------------------------------------------------------------------------
package nnd_pkg;

    // Storage sizes
    localparam int COORD_STORE = 256;
    localparam int ADDR_W      = 8;
    localparam int MAX_NODES   = 32;
    localparam int NODE_W      = 6;
    localparam int MAX_DIMS    = 16;
    localparam int DIM_W       = 5;

    // Datapath widths
    localparam int COORD_W    = 16;
    localparam int DIFF_W     = 17;
    localparam int SQ_W       = 34;
    localparam int DIST_W     = 36;
    localparam int ROOT_W     = 18;
    localparam int OUT_DIST_W = 48;

    // Metric codes
    localparam logic [1:0] METRIC_CITY  = 2'd0;
    localparam logic [1:0] METRIC_SQ    = 2'd1;
    localparam logic [1:0] METRIC_EUCL  = 2'd2;
    localparam logic [1:0] METRIC_CHEB  = 2'd3;

    // Command codes
    localparam logic [1:0] FUNC_NODE    = 2'd0;
    localparam logic [1:0] FUNC_QUERY   = 2'd1;
    localparam logic [1:0] FUNC_RECALC  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_METRIC   = 2'd0;
    localparam logic [1:0] CFG_COUNT    = 2'd1;
    localparam logic [1:0] CFG_LIMIT    = 2'd2;

    localparam logic [OUT_DIST_W-1:0] LIMIT_RESET = 48'd2560000;

endpackage

FILE: src/nearest_node_distance.sv
// ----------------------------------------------------------------------------
// nearest_node_distance
// Nearest node search over a stored node set with four distance metrics.
// ----------------------------------------------------------------------------
// Usage: a command transaction is taken when start is high and busy is low.
// func 0 writes one node coordinate, func 1 writes one query element (with
// last it starts a run), func 2 reruns the stored query. Node writes and
// plain query writes leave busy low. A run walks every node and dimension
// through the node memory read port, taking each coordinate through the
// RD, DIF, SQ and ACC states; each node then enters the distance chain from
// NEND, in the Euclidean metric after a square root wait in SQW. The run
// then pads the chain to 32 stages and shifts results out one per cycle.
// Each result sits on the output ports for one cycle with strobe high; the
// receiver cannot stall. An empty node set gives one result the cycle after
// the command. Config writes (cfg_we, cfg_index, cfg_data) take effect at
// once and must only be made while idle. Reset initializes the control and
// configuration registers and clears the query; the datapath and result
// data registers and node memory are undefined.
// ----------------------------------------------------------------------------
module nearest_node_distance
    import nnd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            func,
    input  logic [ADDR_W-1:0]     addr,
    input  logic signed [15:0]    value,
    input  logic                  last,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [OUT_DIST_W-1:0] cfg_data,
    output logic                  strobe,
    output logic [4:0]            node_index,
    output logic [OUT_DIST_W-1:0] distance,
    output logic [4:0]            nearest,
    output logic                  nearest_valid,
    output logic                  empty_res,
    output logic                  last_result
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_DIF  = 4'd2;
    localparam logic [3:0] S_SQ   = 4'd3;
    localparam logic [3:0] S_ACC  = 4'd4;
    localparam logic [3:0] S_NEND = 4'd5;
    localparam logic [3:0] S_SQW  = 4'd6;
    localparam logic [3:0] S_PAD  = 4'd7;
    localparam logic [3:0] S_EMIT = 4'd8;

    // configuration
    logic [1:0]            metric_reg;
    logic [NODE_W-1:0]     count_reg;
    logic [OUT_DIST_W-1:0] limit_reg;

    // query store
    logic [COORD_W-1:0] query_reg [MAX_DIMS];
    logic [DIM_W-1:0]   fill_reg, fill_next;
    logic [DIM_W-1:0]   dims_reg, dims_next;

    // node memory
    logic [COORD_W-1:0] node_mem [COORD_STORE];
    logic [COORD_W-1:0] rd_reg;

    // control
    logic [3:0]        state_reg, state_next;
    logic [NODE_W-1:0] node_reg, node_next;
    logic [DIM_W-1:0]  dim_reg, dim_next;
    logic [ADDR_W-1:0] raddr_reg, raddr_next;
    logic [NODE_W-1:0] pad_reg, pad_next;
    logic [NODE_W-1:0] runn_reg, runn_next;

    // datapath
    logic [COORD_W-1:0] qv_reg;
    logic [DIFF_W-1:0]  ad_reg, ad_next;
    logic [SQ_W-1:0]    sq_reg;
    logic [DIST_W-1:0]  acc_reg, acc_next;
    logic               bv_reg, bv_next;
    logic [DIST_W-1:0]  bd_reg, bd_next;
    logic [4:0]         best_reg, best_next;

    // output registers
    logic                  strobe_reg, strobe_next;
    logic [4:0]            idx_reg, idx_next;
    logic [OUT_DIST_W-1:0] dist_reg, dist_next;
    logic [4:0]            near_reg, near_next;
    logic                  nv_reg, nv_next;
    logic                  empty_reg, empty_next;
    logic                  lastr_reg, lastr_next;

    logic              accept;
    logic              launch;
    logic [NODE_W-1:0] n_clamp;
    logic              fin_en;
    logic [DIST_W-1:0] fin_dist;
    logic              chain_shift;
    logic [DIST_W-1:0] chain_in;
    logic [DIST_W-1:0] chain [MAX_NODES+1];
    logic              sqrt_start;
    logic              sqrt_done;
    logic [ROOT_W-1:0] sqrt_root;
    logic signed [DIFF_W-1:0] diff;
    logic              qwrite;

    assign accept  = start && (state_reg == S_IDLE);
    assign busy    = (state_reg != S_IDLE);
    assign n_clamp = (count_reg > NODE_W'(MAX_NODES)) ? NODE_W'(MAX_NODES) : count_reg;
    assign qwrite  = accept && (func == FUNC_QUERY) && (fill_reg < DIM_W'(MAX_DIMS));
    assign launch  = accept && ((func == FUNC_RECALC) || ((func == FUNC_QUERY) && last));

    // query fill and dimension count
    always_comb
    begin
        fill_next = fill_reg;
        dims_next = dims_reg;
        if (qwrite)
        begin
            fill_next = fill_reg + 1'b1;
        end
        if (accept && (func == FUNC_QUERY) && last)
        begin
            dims_next = fill_next;
            fill_next = '0;
        end
    end

    // coordinate difference
    assign diff    = $signed({rd_reg[COORD_W-1], rd_reg}) - $signed({qv_reg[COORD_W-1], qv_reg});
    assign ad_next = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

    // accumulate by metric
    always_comb
    begin
        case (metric_reg)
            METRIC_CITY: acc_next = acc_reg + DIST_W'(ad_reg);
            METRIC_CHEB: acc_next = (DIST_W'(ad_reg) > acc_reg) ? DIST_W'(ad_reg) : acc_reg;
            default:     acc_next = acc_reg + DIST_W'(sq_reg);
        endcase
    end

    // finished node distance
    assign fin_en   = ((state_reg == S_NEND) && (metric_reg != METRIC_EUCL)) ||
                      ((state_reg == S_SQW) && sqrt_done);
    assign fin_dist = (state_reg == S_SQW) ? DIST_W'(sqrt_root) : acc_reg;
    assign sqrt_start = (state_reg == S_NEND) && (metric_reg == METRIC_EUCL);

    // best node tracking
    always_comb
    begin
        bv_next   = bv_reg;
        bd_next   = bd_reg;
        best_next = best_reg;
        if (launch)
        begin
            bv_next   = 1'b0;
            best_next = '0;
        end
        else if (fin_en && (OUT_DIST_W'(fin_dist) < limit_reg) && (!bv_reg || fin_dist < bd_reg))
        begin
            bv_next   = 1'b1;
            bd_next   = fin_dist;
            best_next = node_reg[4:0];
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        node_next  = node_reg;
        dim_next   = dim_reg;
        raddr_next = raddr_reg;
        pad_next   = pad_reg;
        runn_next  = runn_reg;
        unique case (state_reg) inside
            S_IDLE:
            begin
                if (launch && (n_clamp != '0))
                begin
                    state_next = S_RD;
                    node_next  = '0;
                    dim_next   = '0;
                    raddr_next = '0;
                    runn_next  = n_clamp;
                end
            end
            S_RD:  state_next = S_DIF;
            S_DIF: state_next = S_SQ;
            S_SQ:  state_next = S_ACC;
            S_ACC:
            begin
                raddr_next = raddr_reg + 1'b1;
                dim_next   = dim_reg + 1'b1;
                state_next = (dim_reg + 1'b1 == dims_reg) ? S_NEND : S_RD;
            end
            S_NEND, S_SQW:
            begin
                if (fin_en)
                begin
                    node_next = node_reg + 1'b1;
                    dim_next  = '0;
                    pad_next  = NODE_W'(MAX_NODES) - runn_reg;
                    if (node_reg + 1'b1 != runn_reg)
                    begin
                        state_next = S_RD;
                    end
                    else if (runn_reg == NODE_W'(MAX_NODES))
                    begin
                        state_next = S_EMIT;
                        node_next  = '0;
                    end
                    else
                    begin
                        state_next = S_PAD;
                    end
                end
                else if (state_reg == S_NEND)
                begin
                    state_next = S_SQW;
                end
            end
            S_PAD:
            begin
                pad_next = pad_reg - 1'b1;
                if (pad_reg == NODE_W'(1))
                begin
                    state_next = S_EMIT;
                    node_next  = '0;
                end
            end
            S_EMIT:
            begin
                node_next = node_reg + 1'b1;
                if (node_reg + 1'b1 == runn_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // result outputs
    always_comb
    begin
        strobe_next = 1'b0;
        idx_next    = '0;
        dist_next   = '0;
        near_next   = '0;
        nv_next     = 1'b0;
        empty_next  = 1'b0;
        lastr_next  = 1'b0;
        if (launch && (n_clamp == '0))
        begin
            strobe_next = 1'b1;
            empty_next  = 1'b1;
            lastr_next  = 1'b1;
        end
        else if (state_reg == S_EMIT)
        begin
            strobe_next = 1'b1;
            idx_next    = node_reg[4:0];
            dist_next   = OUT_DIST_W'(chain[MAX_NODES]);
            near_next   = bv_reg ? best_reg : 5'd0;
            nv_next     = bv_reg;
            lastr_next  = (node_reg + 1'b1 == runn_reg);
        end
    end

    // distance chain
    assign chain_shift = fin_en || (state_reg == S_PAD) || (state_reg == S_EMIT);
    assign chain_in    = fin_en ? fin_dist : '0;
    assign chain[0]    = chain_in;

    for (genvar i = 0; i < MAX_NODES; i++)
    begin : g_chain
        nnd_cell u_cell
        (
            .clk   (clk),
            .shift (chain_shift),
            .din   (chain[i]),
            .dout  (chain[i+1])
        );
    end

    nnd_isqrt u_isqrt
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sqrt_start),
        .operand (acc_reg),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    // node memory
    always_ff @(posedge clk)
    begin
        if (accept && (func == FUNC_NODE))
        begin
            node_mem[addr] <= value;
        end
        rd_reg <= node_mem[raddr_reg];
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_RD)
        begin
            qv_reg <= query_reg[dim_reg[DIM_W-2:0]];
        end
        if (state_reg == S_DIF)
        begin
            ad_reg <= ad_next;
        end
        if (state_reg == S_SQ)
        begin
            sq_reg <= SQ_W'(ad_reg) * SQ_W'(ad_reg);
        end
        if ((state_reg == S_IDLE) || fin_en)
        begin
            acc_reg <= '0;
        end
        else if (state_reg == S_ACC)
        begin
            acc_reg <= acc_next;
        end
        bd_reg    <= bd_next;
        idx_reg   <= idx_next;
        dist_reg  <= dist_next;
        near_reg  <= near_next;
        nv_reg    <= nv_next;
        empty_reg <= empty_next;
        lastr_reg <= lastr_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            node_reg   <= '0;
            dim_reg    <= '0;
            raddr_reg  <= '0;
            pad_reg    <= '0;
            runn_reg   <= '0;
            fill_reg   <= '0;
            dims_reg   <= DIM_W'(1);
            bv_reg     <= 1'b0;
            best_reg   <= '0;
            strobe_reg <= 1'b0;
            metric_reg <= METRIC_CITY;
            count_reg  <= '0;
            limit_reg  <= LIMIT_RESET;
            for (int k = 0; k < MAX_DIMS; k++)
            begin
                query_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            node_reg   <= node_next;
            dim_reg    <= dim_next;
            raddr_reg  <= raddr_next;
            pad_reg    <= pad_next;
            runn_reg   <= runn_next;
            fill_reg   <= fill_next;
            dims_reg   <= dims_next;
            bv_reg     <= bv_next;
            best_reg   <= best_next;
            strobe_reg <= strobe_next;
            if (qwrite)
            begin
                query_reg[fill_reg[DIM_W-2:0]] <= value;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_METRIC: metric_reg <= cfg_data[1:0];
                    CFG_COUNT:  count_reg  <= cfg_data[NODE_W-1:0];
                    CFG_LIMIT:  limit_reg  <= cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    assign strobe        = strobe_reg;
    assign node_index    = idx_reg;
    assign distance      = dist_reg;
    assign nearest       = near_reg;
    assign nearest_valid = nv_reg;
    assign empty_res     = empty_reg;
    assign last_result   = lastr_reg;

endmodule

FILE: src/nnd_cell.sv
// ----------------------------------------------------------------------------
// nnd_cell
// One stage of the distance chain: holds one node distance and hands it to
// the next stage on every shift.
// ----------------------------------------------------------------------------
module nnd_cell
    import nnd_pkg::*;
(
    input  logic              clk,
    input  logic              shift,
    input  logic [DIST_W-1:0] din,
    output logic [DIST_W-1:0] dout
);

    logic [DIST_W-1:0] dist_reg;

    // shift stage
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            dist_reg <= din;
        end
    end

    assign dout = dist_reg;

endmodule

FILE: src/nnd_isqrt.sv
// ----------------------------------------------------------------------------
// nnd_isqrt
// Iterative floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module nnd_isqrt
    import nnd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIST_W-1:0] operand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int STEPS = DIST_W / 2;

    logic [DIST_W:0]   rem_reg, rem_next;
    logic [DIST_W:0]   res_reg, res_next;
    logic [DIST_W-1:0] bit_reg, bit_next;
    logic [DIM_W-1:0]  cnt_reg, cnt_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [DIST_W:0]   trial;

    assign trial = res_reg + {1'b0, bit_reg};

    // one digit per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = {1'b0, operand};
            res_next = '0;
            bit_next = {2'b01, {(DIST_W-2){1'b0}}};
            cnt_next = DIM_W'(STEPS - 1);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_next = rem_reg - trial;
                res_next = (res_reg >> 1) + {1'b0, bit_reg};
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
        cnt_reg <= cnt_next;
    end

    assign done = done_reg;
    assign root = res_reg[ROOT_W-1:0];

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for nearest_node_distance. The low node entries are
// loaded first and every run stays within them; directed commands cover the
// metrics, the empty set, large node counts, query overflow, recompute and
// ignored commands. Random phases with varied sender idling and register
// settings follow. A scoreboard predicts every distance result and checks
// each strobed result in order.
// ----------------------------------------------------------------------------
module testbench;
    import nnd_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int         CYCLE_LIMIT = 1500000;
    localparam int         SETTLE      = 40;
    localparam int         LOADED      = 32;

    typedef struct packed {
        logic [4:0]            node_index;
        logic [OUT_DIST_W-1:0] distance;
        logic [4:0]            nearest;
        logic                  nearest_valid;
        logic                  empty_res;
        logic                  last_result;
    } nn_result_t;

    // Predicts results of the node search and checks them in order
    class nnd_scoreboard;
        logic [COORD_W-1:0]    node_mem [COORD_STORE];
        logic [COORD_W-1:0]    qvec [MAX_DIMS];
        int unsigned           qfill;
        int unsigned           qdims;
        logic [1:0]            metric_r;
        logic [5:0]            count_r;
        logic [OUT_DIST_W-1:0] limit_r;
        nn_result_t            pending [$];
        int                    errors;
        int                    checked;
        int                    runs;

        function new();
            foreach (node_mem[i]) node_mem[i] = '0;
            foreach (qvec[i]) qvec[i] = '0;
            qfill    = 0;
            qdims    = 1;
            metric_r = METRIC_CITY;
            count_r  = '0;
            limit_r  = LIMIT_RESET;
            errors   = 0;
            checked  = 0;
            runs     = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [OUT_DIST_W-1:0] data);
            case (idx)
                CFG_METRIC: metric_r = data[1:0];
                CFG_COUNT:  count_r  = data[5:0];
                CFG_LIMIT:  limit_r  = data;
                default:    ;
            endcase
        endfunction

        function logic [63:0] floor_root(logic [63:0] v);
            logic [63:0] r;
            logic [63:0] t;
            r = 0;
            for (int b = 20; b >= 0; b--)
            begin
                t = r | (64'd1 << b);
                if (t * t <= v)
                    r = t;
            end
            return r;
        endfunction

        function logic [OUT_DIST_W-1:0] distance_to(int node);
            logic [63:0] acc;
            logic [63:0] ad;
            int          a;
            int          d;
            acc = 0;
            for (int j = 0; j < qdims; j++)
            begin
                a  = (node * qdims + j) % COORD_STORE;
                d  = int'($signed(node_mem[a])) - int'($signed(qvec[j]));
                ad = (d < 0) ? 64'(-d) : 64'(d);
                case (metric_r) inside
                    METRIC_CITY:             acc = acc + ad;
                    METRIC_SQ, METRIC_EUCL:  acc = acc + ad * ad;
                    default:                 if (ad > acc) acc = ad;
                endcase
            end
            if (metric_r == METRIC_EUCL)
                acc = floor_root(acc);
            return acc[OUT_DIST_W-1:0];
        endfunction

        function void predict_run();
            logic [OUT_DIST_W-1:0] node_dist [MAX_NODES];
            logic [OUT_DIST_W-1:0] bestd;
            nn_result_t            r;
            int                    n;
            int                    best;
            bit                    found;
            runs++;
            n     = (count_r > MAX_NODES) ? MAX_NODES : count_r;
            best  = 0;
            found = 0;
            bestd = '0;
            if (n == 0)
            begin
                r = '0;
                r.empty_res   = 1'b1;
                r.last_result = 1'b1;
                pending.push_back(r);
                return;
            end
            for (int i = 0; i < n; i++)
            begin
                node_dist[i] = distance_to(i);
                if (node_dist[i] < limit_r && (!found || node_dist[i] < bestd))
                begin
                    found = 1;
                    bestd = node_dist[i];
                    best  = i;
                end
            end
            for (int i = 0; i < n; i++)
            begin
                r.node_index    = 5'(i);
                r.distance      = node_dist[i];
                r.nearest       = found ? 5'(best) : 5'd0;
                r.nearest_valid = found;
                r.empty_res     = 1'b0;
                r.last_result   = (i + 1 == n);
                pending.push_back(r);
            end
        endfunction

        // Accepted command transaction
        function void note_input(logic [1:0] f, logic [ADDR_W-1:0] a,
                                 logic [COORD_W-1:0] v, logic l);
            case (f)
                FUNC_NODE:
                    node_mem[a] = v;
                FUNC_QUERY:
                begin
                    if (qfill < MAX_DIMS)
                    begin
                        qvec[qfill] = v;
                        qfill++;
                    end
                    if (l)
                    begin
                        qdims = qfill;
                        qfill = 0;
                        predict_run();
                    end
                end
                FUNC_RECALC:
                    predict_run();
                default: ;
            endcase
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH @%0t: %s", $realtime, msg);
        endtask

        task check_result(nn_result_t got);
            nn_result_t exp_r;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected result node %0d", got.node_index));
                return;
            end
            exp_r = pending.pop_front();
            checked++;
            if (got.node_index !== exp_r.node_index)
                report($sformatf("node_index %0d, want %0d",
                                 got.node_index, exp_r.node_index));
            if (got.distance !== exp_r.distance)
                report($sformatf("node %0d distance %0d, want %0d",
                                 exp_r.node_index, got.distance, exp_r.distance));
            if (got.nearest !== exp_r.nearest)
                report($sformatf("node %0d nearest %0d, want %0d",
                                 exp_r.node_index, got.nearest, exp_r.nearest));
            if (got.nearest_valid !== exp_r.nearest_valid)
                report($sformatf("node %0d nearest_valid %0b, want %0b",
                                 exp_r.node_index, got.nearest_valid,
                                 exp_r.nearest_valid));
            if (got.empty_res !== exp_r.empty_res)
                report($sformatf("empty_res %0b, want %0b",
                                 got.empty_res, exp_r.empty_res));
            if (got.last_result !== exp_r.last_result)
                report($sformatf("node %0d last_result %0b, want %0b",
                                 exp_r.node_index, got.last_result,
                                 exp_r.last_result));
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [1:0]            func = FUNC_NODE;
    logic [ADDR_W-1:0]     addr = '0;
    logic signed [15:0]    value = '0;
    logic                  last = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [1:0]            cfg_index = CFG_METRIC;
    logic [OUT_DIST_W-1:0] cfg_data = '0;
    logic                  strobe;
    logic [4:0]            node_index;
    logic [OUT_DIST_W-1:0] distance;
    logic [4:0]            nearest;
    logic                  nearest_valid;
    logic                  empty_res;
    logic                  last_result;

    nnd_scoreboard sb = new();
    int            gap_pct = 0;
    int            cycles = 0;
    int            sent = 0;

    nearest_node_distance dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .addr          (addr),
        .value         (value),
        .last          (last),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .strobe        (strobe),
        .node_index    (node_index),
        .distance      (distance),
        .nearest       (nearest),
        .nearest_valid (nearest_valid),
        .empty_res     (empty_res),
        .last_result   (last_result)
    );

    always #10 clk = ~clk;

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && strobe === 1'b1)
            sb.check_result('{node_index, distance, nearest, nearest_valid,
                              empty_res, last_result});
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("nearest_node_distance verification failed");
            $finish;
        end
    end

    // One command transaction, then idle cycles drawn at the phase's idle rate
    task send_cmd(logic [1:0] f, logic [ADDR_W-1:0] a, logic [15:0] v, logic l);
        @(negedge clk);
        start = 1'b1;
        func  = f;
        addr  = a;
        value = v;
        last  = l;
        do @(posedge clk); while (busy !== 1'b0);
        sb.note_input(f, a, v, l);
        sent++;
        while ($urandom_range(99) < gap_pct)
        begin
            @(negedge clk);
            start = 1'b0;
        end
    endtask

    // Hold the sender until the block is idle and all results are in
    task drain();
        @(negedge clk);
        start = 1'b0;
        while (sb.pending.size() != 0 || busy !== 1'b0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task write_reg(logic [1:0] idx, logic [OUT_DIST_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        sb.set_reg(idx, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task query_seq(int n, logic [15:0] v);
        for (int i = 0; i < n; i++)
            send_cmd(FUNC_QUERY, 8'($urandom), (i == 0) ? v : 16'($urandom),
                     i == n - 1);
    endtask

    // Random commands; every run reads only the loaded node entries
    task random_phase(int items);
        int done;
        int k;
        int pick;
        int n;
        int maxd;
        done = 0;
        n    = (sb.count_r > MAX_NODES) ? MAX_NODES : int'(sb.count_r);
        maxd = (n == 0) ? MAX_DIMS : LOADED / n;
        if (maxd > MAX_DIMS)
            maxd = MAX_DIMS;
        while (done < items)
        begin
            pick = $urandom_range(99);
            if (pick >= 85 && pick < 95 && sb.qdims * n > LOADED)
                pick = 0;
            if (pick < 65)
            begin
                if (maxd == MAX_DIMS && $urandom_range(9) == 0)
                    k = $urandom_range(14, 18);
                else
                    k = $urandom_range(1, (maxd < 5) ? maxd : 5);
                query_seq(k, 16'($urandom));
                done += k;
            end
            else if (pick < 85)
            begin
                k = $urandom_range(1, 4);
                repeat (k)
                    send_cmd(FUNC_NODE, 8'($urandom), 16'($urandom),
                             1'($urandom));
                done += k;
            end
            else if (pick < 95)
            begin
                send_cmd(FUNC_RECALC, 8'($urandom), 16'($urandom), 1'($urandom));
                done++;
            end
            else
            begin
                send_cmd(FUNC_UNUSED, 8'($urandom), 16'($urandom), 1'($urandom));
                done++;
            end
        end
    endtask

    initial
    begin
        int gaps [4];
        gaps = '{0, 86, 0, 26};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (4) @(posedge clk);

        // Load the node entries that every run reads
        for (int i = 0; i < LOADED; i++)
            send_cmd(FUNC_NODE, 8'(i), (i == 0) ? 16'h8000 :
                     (i == 1) ? 16'h7FFF : 16'($urandom), 1'b0);

        // Empty node set, by query and by recompute
        query_seq(1, 16'h0000);
        send_cmd(FUNC_RECALC, 8'hFF, 16'hFFFF, 1'b1);
        drain();

        // Each metric on extreme coordinates
        write_reg(CFG_COUNT, 48'd4);
        for (int m = 0; m < 4; m++)
        begin
            write_reg(CFG_METRIC, 48'(m));
            send_cmd(FUNC_QUERY, 8'h00, 16'h7FFF, 1'b0);
            send_cmd(FUNC_QUERY, 8'h00, 16'h8000, 1'b1);
            send_cmd(FUNC_RECALC, 8'h00, 16'h0000, 1'b0);
            drain();
        end

        // Query overflow past the dimension limit, then large node count,
        // no match possible, ignored command and node write with last
        write_reg(CFG_METRIC, 48'(METRIC_EUCL));
        write_reg(CFG_COUNT, 48'd2);
        query_seq(18, 16'h8000);
        drain();
        write_reg(CFG_COUNT, 48'd63);
        query_seq(1, 16'h8000);
        drain();
        write_reg(CFG_LIMIT, 48'd0);
        send_cmd(FUNC_UNUSED, 8'hAA, 16'h5555, 1'b1);
        send_cmd(FUNC_NODE, 8'h3C, 16'h1234, 1'b1);
        send_cmd(FUNC_RECALC, 8'h00, 16'h0000, 1'b0);
        drain();
        write_reg(CFG_LIMIT, 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_METRIC, 48'(METRIC_SQ));
        query_seq(1, 16'h7FFF);
        drain();

        // Random phases, each with its own register setting
        for (int p = 0; p < 4; p++)
        begin
            gap_pct = gaps[p];
            write_reg(CFG_METRIC, 48'($urandom_range(3)));
            write_reg(CFG_COUNT, ($urandom_range(4) == 0) ?
                      48'($urandom_range(33, 63)) : 48'($urandom_range(0, 12)));
            write_reg(CFG_LIMIT, ($urandom_range(1) == 1) ?
                      {16'($urandom), 32'($urandom)} : 48'($urandom_range(0, 4000000)));
            random_phase(4);
            drain();
            random_phase(4);
            drain();
        end

        $display("covered %0d command transactions, %0d search runs, %0d results",
                 sent, sb.runs, sb.checked);
        $display("all four metrics, empty and oversized node sets, query overflow");
        if (sb.errors == 0)
            $display("nearest_node_distance verification clean");
        else
            $display("nearest_node_distance verification failed");
        $finish;
    end

endmodule
